// ===== rtl/lchc_pkg.sv =====
// ----------------------------------------------------------------------------
// lchc_pkg
// Shared widths, cost constants and the control struct that the cache's
// top level hands to every cell of the recency chain.
// ----------------------------------------------------------------------------
package lchc_pkg;

  localparam int SIZE_W     = 6;
  localparam int CITY_KEY_W = 64;
  localparam int COST_W     = 3;
  localparam int TOTAL_W    = 32;

  localparam logic [SIZE_W-1:0]  SIZE_RESET = 6'd3;
  localparam logic [COST_W-1:0]  HIT_COST   = 3'd1;
  localparam logic [COST_W-1:0]  MISS_COST  = 3'd5;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX  = 32'hFFFF_FFFF;

  // Control broadcast from the top level to all cells.
  typedef struct packed {
    logic              accept;  // request taken: latch the compare result
    logic              upd;     // apply the pending request to the chain
    logic              ins;     // miss with ways in use: shift the whole chain
    logic              trunc;   // size written: drop entries at or past it
    logic [SIZE_W-1:0] size;    // ways in use (new value during trunc)
  } lchc_ctl_t;

endpackage

// ===== rtl/lchc_if.sv =====
// ----------------------------------------------------------------------------
// lchc channel interfaces
// Valid/ready channels for access requests, results and size writes.
// ----------------------------------------------------------------------------
interface lchc_in_if;
  import lchc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CITY_KEY_W-1:0] city_key;

  modport source (output valid, output city_key, input ready);
  modport sink   (input valid, input city_key, output ready);
endinterface

interface lchc_out_if;
  import lchc_pkg::*;
  logic               valid;
  logic               ready;
  logic               hit;
  logic [COST_W-1:0]  access_cost;
  logic [TOTAL_W-1:0] total_cost;

  modport source (output valid, output hit, output access_cost, output total_cost,
                  input ready);
  modport sink   (input valid, input hit, input access_cost, input total_cost,
                  output ready);
endinterface

interface lchc_cfg_if;
  import lchc_pkg::*;
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/lchc_cell.sv =====
// ----------------------------------------------------------------------------
// lchc_cell
// One way of the recency chain: holds a key and its valid bit, compares the
// incoming key, and takes its neighbor's entry when the chain shifts.
// ----------------------------------------------------------------------------
module lchc_cell
  import lchc_pkg::*;
#(
  parameter int KEY_BITS = 64,
  parameter int IDX      = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lchc_ctl_t           ctl,
  input  logic [KEY_BITS-1:0] cmp_key,
  input  logic [KEY_BITS-1:0] prev_key,
  input  logic                prev_valid,
  input  logic                shift_in,
  output logic [KEY_BITS-1:0] key_o,
  output logic                valid_o,
  output logic                shift_o
);

  localparam logic [SIZE_W-1:0] IDX_C = SIZE_W'(IDX);

  logic [KEY_BITS-1:0] key_r;
  logic                valid_r, valid_nxt;
  logic                match_r, match_nxt;
  logic                in_use;
  logic                take;

  assign in_use = IDX_C < ctl.size;

  // Shift when the hit lies here or further from the head, or on an insert.
  assign shift_o = match_r | shift_in;
  assign take    = ctl.upd && (ctl.ins || shift_o);

  // Latch the compare result when the request is taken.
  always_comb begin
    match_nxt = match_r;
    if (ctl.accept) begin
      match_nxt = valid_r && (key_r == cmp_key);
    end else if (ctl.upd) begin
      match_nxt = 1'b0;
    end
  end

  // Advance the valid bit along the chain; drop it past the ways in use.
  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = prev_valid && in_use;
    end else if (ctl.trunc) begin
      valid_nxt = valid_r && in_use;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      match_r <= match_nxt;
    end
  end

  // Take the neighbor's key on a shift.
  always_ff @(posedge clk) begin
    if (take) begin
      key_r <= prev_key;
    end
  end

  assign key_o   = key_r;
  assign valid_o = valid_r;

endmodule

// ===== rtl/lchc_acc.sv =====
// ----------------------------------------------------------------------------
// lchc_acc
// Saturating running total of access costs.
// ----------------------------------------------------------------------------
module lchc_acc
  import lchc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               upd,
  input  logic [COST_W-1:0]  cost,
  output logic [TOTAL_W-1:0] sum_nxt
);

  logic [TOTAL_W-1:0] sum_r;
  logic [TOTAL_W:0]   sum_wide;

  // Add with carry out; hold at the maximum on overflow.
  assign sum_wide = {1'b0, sum_r} + (TOTAL_W+1)'(cost);
  assign sum_nxt  = sum_wide[TOTAL_W] ? TOTAL_MAX : sum_wide[TOTAL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (upd) begin
      sum_r <= sum_nxt;
    end
  end

endmodule

// ===== rtl/lru_cache_hit_cost_top.sv =====
// ----------------------------------------------------------------------------
// lru_cache_hit_cost_top
// Fully associative LRU tag cache with hit/miss cost accounting.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one access request per item, carrying city_key. Only the low
//            KEY_BITS bits are compared and stored.
//   out_ch : one result per request: hit, access_cost (1 hit, 5 miss) and
//            total_cost, the saturating sum of costs since reset.
//   cfg_ch : writes cache_size (ways in use, 0 = cache nothing, values above
//            CAPACITY act as CAPACITY). Always ready; write only while idle.
//            Lowering the size drops the least recent entries.
// Operation:
//   When a request is accepted, every cell latches its tag compare; once the
//   result register is free or being read, the update step shifts the recency
//   chain and loads the result register. A new request is taken only after
//   the pending one has completed its compare-then-shift steps in the chain.
// Reset (rst_n low, synchronous) empties the cache, clears the total and
// sets cache_size to 3. When out_ch stalls, the result register holds; one
// more request may be accepted and waits until the result is taken.
// ----------------------------------------------------------------------------
module lru_cache_hit_cost_top
  import lchc_pkg::*;
#(
  parameter int CAPACITY = 32,
  parameter int KEY_BITS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  lchc_in_if.sink    in_ch,
  lchc_out_if.source out_ch,
  lchc_cfg_if.sink   cfg_ch
);

  logic                busy_r, busy_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SIZE_W-1:0]   size_r;
  logic [KEY_BITS-1:0] key_r;
  logic [KEY_BITS-1:0] cmp_key;
  logic                accept, upd, cfg_wr, any_hit;
  logic                out_hit_r;
  logic [COST_W-1:0]   out_cost_r;
  logic [TOTAL_W-1:0]  out_total_r;
  logic [COST_W-1:0]   cost;
  logic [TOTAL_W-1:0]  sum_nxt;
  lchc_ctl_t           ctl;

  logic [KEY_BITS-1:0] cell_key   [CAPACITY];
  logic                cell_valid [CAPACITY];
  logic [KEY_BITS-1:0] prev_key   [CAPACITY];
  logic                prev_valid [CAPACITY];
  logic                shift_w    [CAPACITY+1];

  assign cmp_key      = in_ch.city_key[KEY_BITS-1:0];
  assign in_ch.ready  = !busy_r;
  assign cfg_ch.ready = 1'b1;
  assign accept       = in_ch.valid && !busy_r;
  assign cfg_wr       = cfg_ch.valid;
  assign upd          = busy_r && (!out_valid_r || out_ch.ready);
  assign any_hit      = shift_w[0];

  // Broadcast control to the chain.
  always_comb begin
    ctl        = '0;
    ctl.accept = accept;
    ctl.upd    = upd;
    ctl.ins    = !any_hit && (size_r != '0);
    ctl.trunc  = cfg_wr;
    ctl.size   = cfg_wr ? cfg_ch.data : size_r;
  end

  // Build the chain: head takes the request key, each cell its neighbor's.
  assign shift_w[CAPACITY] = 1'b0;
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_key[i]   = key_r;
      assign prev_valid[i] = 1'b1;
    end else begin : g_link
      assign prev_key[i]   = cell_key[i-1];
      assign prev_valid[i] = cell_valid[i-1];
    end

    lchc_cell #(
      .KEY_BITS (KEY_BITS),
      .IDX      (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .cmp_key    (cmp_key),
      .prev_key   (prev_key[i]),
      .prev_valid (prev_valid[i]),
      .shift_in   (shift_w[i+1]),
      .key_o      (cell_key[i]),
      .valid_o    (cell_valid[i]),
      .shift_o    (shift_w[i])
    );
  end

  assign cost = any_hit ? HIT_COST : MISS_COST;

  lchc_acc u_acc (
    .clk     (clk),
    .rst_n   (rst_n),
    .upd     (upd),
    .cost    (cost),
    .sum_nxt (sum_nxt)
  );

  // Track the pending request and the result register.
  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (upd) begin
      busy_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (upd) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      size_r      <= SIZE_RESET;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        size_r <= cfg_ch.data;
      end
    end
  end

  // Hold the request key and load the result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      key_r <= cmp_key;
    end
    if (upd) begin
      out_hit_r   <= any_hit;
      out_cost_r  <= cost;
      out_total_r <= sum_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.hit         = out_hit_r;
  assign out_ch.access_cost = out_cost_r;
  assign out_ch.total_cost  = out_total_r;

endmodule

// ===== rtl/lchc_chk.sv =====
// ----------------------------------------------------------------------------
// lchc_chk
// Port-level checks of the cache's request and result channels.
// ----------------------------------------------------------------------------
module lchc_chk
  import lchc_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_hit,
  input logic [COST_W-1:0]  out_access_cost,
  input logic [TOTAL_W-1:0] out_total_cost
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit) &&
      $stable(out_access_cost) && $stable(out_total_cost))
    else $error("stalled result changed");

  // One request at a time: ready drops after a request is taken.
  a_one_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while one is pending");

  // Cost follows the hit flag.
  a_cost: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hit && out_access_cost == HIT_COST) ||
      (!out_hit && out_access_cost == MISS_COST))
    else $error("cost does not match hit flag");

  // With the result register empty, the result shows after the compare and update steps.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> ##1 out_valid)
    else $error("result late");

endmodule

bind lru_cache_hit_cost_top lchc_chk u_lchc_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_hit         (out_ch.hit),
  .out_access_cost (out_ch.access_cost),
  .out_total_cost  (out_ch.total_cost)
);

// ===== tb/lru_cache_hit_cost_top_test.sv =====
// ----------------------------------------------------------------------------
// lru_cache_hit_cost_top_test
// Self-checking bench for the LRU tag cache. A local recency list mirrors
// the cache and predicts hit, cost and running total for every accepted
// request. A directed part covers the default size, size zero, a size
// cut with live entries and a long result hold-off. Random phases then mix
// key reuse with fresh keys under several sizes, sender gaps and result stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_cache_hit_cost_top_test;
  import lchc_pkg::*;

  localparam int CAPACITY    = 32;
  localparam int KEY_POOL_N  = 48;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic               hit;
    logic [COST_W-1:0]  access_cost;
    logic [TOTAL_W-1:0] total_cost;
  } access_result_t;

  logic clk = 1'b0;
  logic rst_n;

  lchc_in_if  in_ch();
  lchc_out_if out_ch();
  lchc_cfg_if cfg_ch();

  lru_cache_hit_cost_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Mirror of the cache: slot 0 least recent, slot lru_count-1 most recent
  logic [CITY_KEY_W-1:0] lru_keys [CAPACITY];
  int                    lru_count = 0;
  logic [SIZE_W-1:0]     ways_cfg = SIZE_RESET;
  logic [TOTAL_W-1:0]    cost_total = '0;

  access_result_t        expected_results [$];
  logic [CITY_KEY_W-1:0] key_pool [KEY_POOL_N];

  int sender_idle_pct  = 0;
  int result_stall_pct = 0;
  int hold_cycles      = 0;
  int error_count      = 0;
  int hit_count        = 0;
  int miss_count       = 0;
  int size_writes      = 0;
  int unsigned cycle_count = 0;

  // Free-running clock, 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, CYCLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic int ways_in_use();
    return (ways_cfg > CAPACITY) ? CAPACITY : int'(ways_cfg);
  endfunction

  // Drop the n least recent keys and close the gap
  function automatic void drop_least_recent(input int n);
    if (n > lru_count) n = lru_count;
    for (int i = 0; i + n < lru_count; i++) lru_keys[i] = lru_keys[i + n];
    lru_count -= n;
  endfunction

  function automatic void apply_cache_size(input logic [SIZE_W-1:0] ways);
    ways_cfg = ways;
    if (lru_count > ways_in_use()) drop_least_recent(lru_count - ways_in_use());
  endfunction

  function automatic void predict_access(input logic [CITY_KEY_W-1:0] key);
    access_result_t     want;
    int                 pos;
    logic [TOTAL_W:0]   next_total;
    pos = -1;
    for (int i = 0; i < lru_count; i++) begin
      if (pos < 0 && lru_keys[i] == key) pos = i;
    end
    if (pos >= 0) begin
      // hit: move the key to most recent
      for (int i = pos; i + 1 < lru_count; i++) lru_keys[i] = lru_keys[i + 1];
      lru_keys[lru_count - 1] = key;
      want.hit = 1'b1;
      want.access_cost = HIT_COST;
      hit_count++;
    end else begin
      // miss: evict the oldest if full, then insert as most recent
      want.hit = 1'b0;
      want.access_cost = MISS_COST;
      miss_count++;
      if (ways_in_use() > 0) begin
        if (lru_count >= ways_in_use()) drop_least_recent(lru_count - ways_in_use() + 1);
        lru_keys[lru_count] = key;
        lru_count++;
      end
    end
    // saturate the running total
    next_total = {1'b0, cost_total} + want.access_cost;
    cost_total = next_total[TOTAL_W] ? TOTAL_MAX : next_total[TOTAL_W-1:0];
    want.total_cost = cost_total;
    expected_results.insert(expected_results.size(), want);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stalls plus an optional long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= result_stall_pct);
      end
    end
  end

  // Compare each taken result with the oldest prediction
  always @(posedge clk) begin
    access_result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result hit=%0b cost=%0d total=%0d", $time,
                 out_ch.hit, out_ch.access_cost, out_ch.total_cost);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_ch.hit !== want.hit) begin
          $display("%0t: hit mismatch, expected %0b, got %0b", $time, want.hit, out_ch.hit);
          error_count++;
        end
        if (out_ch.access_cost !== want.access_cost) begin
          $display("%0t: access_cost mismatch, expected %0d, got %0d", $time,
                   want.access_cost, out_ch.access_cost);
          error_count++;
        end
        if (out_ch.total_cost !== want.total_cost) begin
          $display("%0t: total_cost mismatch, expected %0d, got %0d", $time,
                   want.total_cost, out_ch.total_cost);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------------
  // Offer one request, with random idle cycles ahead of it
  task automatic send_access(input logic [CITY_KEY_W-1:0] key);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid    <= 1'b1;
    in_ch.city_key <= key;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_access(key);
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cache_size(input logic [SIZE_W-1:0] ways);
    drain_results();
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= ways;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    apply_cache_size(ways);
    size_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [CITY_KEY_W-1:0] pick_key();
    int span;
    if ($urandom_range(9) == 0) return {$urandom, $urandom};
    // draw from a pool a bit wider than the ways in use so hits and evictions mix
    span = ways_in_use() + ways_in_use() / 2 + 2;
    if (span > KEY_POOL_N) span = KEY_POOL_N;
    return key_pool[$urandom_range(span - 1)];
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset size of three: fill, hit, then evict in recency order
  task automatic test_default_size();
    send_access('0);
    send_access('1);
    send_access({CITY_KEY_W/2{2'b10}});
    send_access('0);
    send_access({CITY_KEY_W/2{2'b01}});
    send_access('1);
    send_access({CITY_KEY_W/2{2'b10}});
    send_access({CITY_KEY_W/2{2'b01}});
  endtask

  // Size zero caches nothing: repeats still miss
  task automatic test_size_zero();
    write_cache_size('0);
    send_access('0);
    send_access('0);
    send_access('1);
  endtask

  // Lower the size with live entries: the oldest ones go
  task automatic test_size_lowered();
    write_cache_size(SIZE_W'(4));
    send_access(64'h0000_0000_0000_0001);
    send_access(64'h8000_0000_0000_0000);
    send_access(64'h0123_4567_89AB_CDEF);
    send_access(64'hFEDC_BA98_7654_3210);
    write_cache_size(SIZE_W'(2));
    send_access(64'h0123_4567_89AB_CDEF);
    send_access(64'h0000_0000_0000_0001);
    send_access(64'hFEDC_BA98_7654_3210);
  endtask

  // Hold results back long enough that the input stalls
  task automatic test_result_holdoff();
    write_cache_size(SIZE_W'(8));
    sender_idle_pct  = 0;
    result_stall_pct = 0;
    hold_cycles      = 80;
    repeat (12) send_access(pick_key());
    drain_results();
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                   input logic [SIZE_W-1:0] ways, input int count);
    write_cache_size(ways);
    sender_idle_pct  = idle_pct;
    result_stall_pct = stall_pct;
    repeat (count) send_access(pick_key());
    drain_results();
    sender_idle_pct  = 0;
    result_stall_pct = 0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.city_key = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.data    = '0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL_N; i++) key_pool[i] = {$urandom, $urandom};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_default_size();
    test_size_zero();
    test_size_lowered();
    test_result_holdoff();

    test_random_phase(0, 0, SIZE_W'(32), 100);
    test_random_phase(0, 0, SIZE_W'(1), 100);
    test_random_phase(46, 0, SIZE_W'(63), 100);
    test_random_phase(46, 0, SIZE_W'(5), 100);
    test_random_phase(0, 46, SIZE_W'(17), 100);
    test_random_phase(0, 46, SIZE_W'(0), 60);
    test_random_phase(24, 24, SIZE_W'(2), 100);
    test_random_phase(24, 24, SIZE_W'(31), 100);

    drain_results();
    repeat (10) @(posedge clk);

    $display("Ran %0d accesses: %0d hits, %0d misses, final total cost %0d",
             hit_count + miss_count, hit_count, miss_count, cost_total);
    $display("Covered %0d cache-size writes (0 to 63), gaps, stalls and a long hold-off",
             size_writes);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
